FILE: rtl/core/lbos_pkg.sv
// ----------------------------------------------------------------------------
// lbos_pkg
// Types, break class codes and decision functions shared by the line break
// opportunity stream.
// ----------------------------------------------------------------------------
package lbos_pkg;

  localparam int ClassW = 5;
  localparam int DecW   = 3;

  typedef logic [ClassW-1:0] cls_t;
  typedef logic [DecW-1:0]   dec_t;

  // Break classes.
  localparam cls_t CLS_XX = 5'd0;
  localparam cls_t CLS_BK = 5'd1;
  localparam cls_t CLS_CM = 5'd2;
  localparam cls_t CLS_SG = 5'd3;
  localparam cls_t CLS_ZW = 5'd4;
  localparam cls_t CLS_GL = 5'd5;
  localparam cls_t CLS_CB = 5'd6;
  localparam cls_t CLS_SP = 5'd7;
  localparam cls_t CLS_BA = 5'd8;
  localparam cls_t CLS_BB = 5'd9;
  localparam cls_t CLS_B2 = 5'd10;
  localparam cls_t CLS_HY = 5'd11;
  localparam cls_t CLS_IN = 5'd12;
  localparam cls_t CLS_NS = 5'd13;
  localparam cls_t CLS_OP = 5'd14;
  localparam cls_t CLS_CL = 5'd15;
  localparam cls_t CLS_QU = 5'd16;
  localparam cls_t CLS_EX = 5'd17;
  localparam cls_t CLS_NU = 5'd18;
  localparam cls_t CLS_IS = 5'd19;
  localparam cls_t CLS_SY = 5'd20;
  localparam cls_t CLS_PR = 5'd21;
  localparam cls_t CLS_PO = 5'd22;
  localparam cls_t CLS_AL = 5'd23;
  localparam cls_t CLS_ID = 5'd24;
  localparam cls_t CLS_AI = 5'd25;
  localparam cls_t CLS_SA = 5'd26;

  // Decisions.
  localparam dec_t DEC_NO_BREAK = 3'd0;
  localparam dec_t DEC_NO_BREAK_WORD = 3'd1;
  localparam dec_t DEC_OPTIONAL = 3'd2;
  localparam dec_t DEC_MANDATORY = 3'd3;
  localparam dec_t DEC_FILLER = 3'd4;

  typedef struct packed {
    logic [4:0] raw_class;
    logic       is_apostrophe;
    logic       is_pair;
    logic       end_of_text;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] decision;
    logic       is_last;
  } out_beat_t;

  typedef struct packed {
    dec_t dec;
    logic pair;
  } entry_t;

  // Work handed from the front to the back: up to three decisions.
  typedef struct packed {
    logic [1:0]       cnt;
    logic             last;
    entry_t [2:0]     ent;
  } bundle_t;

  function automatic cls_t remap(input cls_t raw, input cls_t prev);
    cls_t r;
    if (raw > CLS_SA || raw == CLS_XX || raw == CLS_SG || raw == CLS_CB || raw == CLS_AI)
      r = CLS_AL;
    else if (raw == CLS_CM)
      r = (prev == CLS_SP) ? CLS_AL : prev;
    else if (raw == CLS_SA)
      r = CLS_ID;
    else if (raw == CLS_SP && (prev == CLS_OP || prev == CLS_B2))
      r = prev;
    else
      r = raw;
    return r;
  endfunction

  function automatic dec_t pair_rules(input cls_t c, input cls_t nx);
    dec_t d;
    if (c == CLS_BK) d = DEC_MANDATORY;
    else if (nx == CLS_BK || nx == CLS_SP || nx == CLS_ZW) d = DEC_NO_BREAK;
    else if (c == CLS_ZW) d = DEC_OPTIONAL;
    else if (nx == CLS_CL || nx == CLS_EX || nx == CLS_IS || nx == CLS_SY) d = DEC_NO_BREAK;
    else if (c == CLS_OP || c == CLS_B2) d = DEC_NO_BREAK;
    else if (c == CLS_SP) d = DEC_OPTIONAL;
    else if (c == CLS_GL || nx == CLS_GL) d = DEC_NO_BREAK;
    else if (c == CLS_QU || nx == CLS_QU) d = DEC_NO_BREAK;
    else if (nx == CLS_BA || nx == CLS_HY || nx == CLS_NS || c == CLS_BB) d = DEC_NO_BREAK;
    else if (c == CLS_HY || nx == CLS_BB) d = DEC_OPTIONAL;
    else if (nx == CLS_IN &&
             (c == CLS_AL || c == CLS_ID || c == CLS_IN || c == CLS_NU)) d = DEC_NO_BREAK;
    else if ((c == CLS_ID && nx == CLS_PO) || (c == CLS_AL && nx == CLS_NU) ||
             (c == CLS_NU && nx == CLS_AL)) d = DEC_NO_BREAK;
    else if (nx == CLS_NU && (c == CLS_HY || c == CLS_IS || c == CLS_NU ||
                              c == CLS_PR || c == CLS_SY)) d = DEC_NO_BREAK;
    else if (c == CLS_PR && (nx == CLS_AL || nx == CLS_HY || nx == CLS_ID ||
                             nx == CLS_OP)) d = DEC_NO_BREAK;
    else if (nx == CLS_PO && (c == CLS_CL || c == CLS_NU)) d = DEC_NO_BREAK;
    else if (c == CLS_AL && nx == CLS_AL) d = DEC_NO_BREAK;
    else d = DEC_OPTIONAL;
    return d;
  endfunction

  function automatic dec_t decide(input cls_t c, input cls_t nx, input logic first,
                                  input logic last);
    dec_t d;
    if (first)
      d = (c == CLS_BK) ? DEC_MANDATORY : DEC_NO_BREAK;
    else
      d = pair_rules(c, nx);
    if (d == DEC_NO_BREAK && c == CLS_AL)
      d = DEC_NO_BREAK_WORD;
    if (last && d == DEC_NO_BREAK && (c == CLS_SP || c == CLS_ZW))
      d = DEC_OPTIONAL;
    return d;
  endfunction

endpackage

FILE: rtl/core/lbos_front.sv
// ----------------------------------------------------------------------------
// lbos_front
// Accepts code points, remaps their classes, keeps the two-position
// lookahead and computes the decisions each item releases.
// ----------------------------------------------------------------------------
module lbos_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  lbos_pkg::in_beat_t item,
  input  logic              queue_full,
  output logic              push,
  output lbos_pkg::bundle_t push_data
);
  import lbos_pkg::*;

  cls_t       prev_class;
  logic       prev_apo;
  cls_t       pend0;
  cls_t       pend1;
  logic       pp0;
  logic       pp1;
  logic [1:0] seen;

  cls_t       cur;
  cls_t       pend1_fix;
  logic       accept;
  cls_t       c0, c1, c2;
  logic       p0, p1, p2;
  cls_t       nx0, nx1;
  logic       first0;
  bundle_t    bundle;

  assign item_ready = !queue_full;
  assign accept     = item_valid && item_ready;
  assign cur        = remap(item.raw_class, prev_class);

  // An apostrophe between two letters joins the word.
  assign pend1_fix = (item.raw_class == CLS_AL && seen >= 2'd2 && pend0 == CLS_AL && prev_apo)
                     ? CLS_AL : pend1;

  always_comb begin
    bundle = '0;
    c0 = cur;
    c1 = cur;
    c2 = cur;
    p0 = item.is_pair;
    p1 = item.is_pair;
    p2 = item.is_pair;
    nx0 = CLS_BK;
    nx1 = CLS_BK;
    first0 = 1'b0;
    if (!item.end_of_text) begin
      if (seen >= 2'd2) begin
        bundle.cnt        = 2'd1;
        bundle.ent[0].dec = decide(pend0, pend1_fix, seen == 2'd2, 1'b0);
        bundle.ent[0].pair = pp0;
      end
    end else begin
      priority if (seen >= 2'd2) begin
        c0 = pend0;
        p0 = pp0;
        c1 = pend1_fix;
        p1 = pp1;
        bundle.cnt = 2'd3;
      end else if (seen == 2'd1) begin
        c0 = pend1_fix;
        p0 = pp1;
        bundle.cnt = 2'd2;
      end else begin
        bundle.cnt = 2'd1;
      end
      nx0    = (bundle.cnt > 2'd1) ? c1 : CLS_BK;
      nx1    = (bundle.cnt > 2'd2) ? c2 : CLS_BK;
      first0 = (seen <= 2'd2);
      bundle.last = 1'b1;
      bundle.ent[0].dec  = decide(c0, nx0, first0, bundle.cnt == 2'd1);
      bundle.ent[0].pair = p0;
      bundle.ent[1].dec  = decide(c1, nx1, 1'b0, bundle.cnt == 2'd2);
      bundle.ent[1].pair = p1;
      bundle.ent[2].dec  = decide(c2, CLS_BK, 1'b0, 1'b1);
      bundle.ent[2].pair = p2;
    end
  end

  assign push      = accept && (bundle.cnt != 2'd0);
  assign push_data = bundle;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_class <= CLS_AL;
      prev_apo   <= 1'b0;
      pend0      <= CLS_XX;
      pend1      <= CLS_XX;
      pp0        <= 1'b0;
      pp1        <= 1'b0;
      seen       <= 2'd0;
    end else if (accept) begin
      if (item.end_of_text) begin
        prev_class <= CLS_AL;
        prev_apo   <= 1'b0;
        pend0      <= CLS_XX;
        pend1      <= CLS_XX;
        pp0        <= 1'b0;
        pp1        <= 1'b0;
        seen       <= 2'd0;
      end else begin
        pend0      <= pend1_fix;
        pp0        <= pp1;
        pend1      <= cur;
        pp1        <= item.is_pair;
        prev_class <= cur;
        prev_apo   <= item.is_apostrophe;
        if (seen != 2'd3)
          seen <= seen + 2'd1;
      end
    end
  end

endmodule

FILE: rtl/core/lbos_queue.sv
// ----------------------------------------------------------------------------
// lbos_queue
// Small first-in first-out queue of decision bundles between front and back.
// ----------------------------------------------------------------------------
module lbos_queue #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CntW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push)
      mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push)
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)
        count <= count + 1'b1;
      else if (do_pop && !do_push)
        count <= count - 1'b1;
    end
  end

endmodule

FILE: rtl/core/lbos_back.sv
// ----------------------------------------------------------------------------
// lbos_back
// Walks the head bundle one beat per cycle while the result register is
// free, into it, inserting the filler after surrogate-pair positions.
// ----------------------------------------------------------------------------
module lbos_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               queue_not_empty,
  input  lbos_pkg::bundle_t  head,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_ready,
  output lbos_pkg::out_beat_t result
);
  import lbos_pkg::*;

  logic [1:0] pos;
  logic       phase;
  logic       load;
  logic       at_end;
  logic       done;
  entry_t     cur_ent;
  out_beat_t  beat;

  assign cur_ent = head.ent[pos];
  assign at_end  = (pos == head.cnt - 2'd1);
  assign done    = at_end && (phase || !cur_ent.pair);
  assign load    = queue_not_empty && (!result_valid || result_ready);
  assign pop     = load && done;

  always_comb begin
    if (phase) begin
      beat.decision = DEC_FILLER;
      beat.is_last  = head.last && at_end;
    end else begin
      beat.decision = cur_ent.dec;
      beat.is_last  = head.last && at_end && !cur_ent.pair;
    end
  end

  always_ff @(posedge clk) begin
    if (load)
      result <= beat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      pos          <= 2'd0;
      phase        <= 1'b0;
    end else begin
      if (load)
        result_valid <= 1'b1;
      else if (result_ready)
        result_valid <= 1'b0;
      if (load) begin
        if (done) begin
          pos   <= 2'd0;
          phase <= 1'b0;
        end else if (!phase && cur_ent.pair) begin
          phase <= 1'b1;
        end else begin
          pos   <= pos + 2'd1;
          phase <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: rtl/core/line_break_opportunity_stream.sv
// ----------------------------------------------------------------------------
// line_break_opportunity_stream
// Line break opportunities over a stream of break classes, pair rules LB3
// to LB20 with two positions of lookahead.
//
// Usage: one code point per item beat on the item channel, decisions leave
// one per beat on the result channel, both valid/ready. A position's decision
// needs the next position's class, so a decision is released by the item two
// positions later; the last item of a text flushes up to three decisions.
// A position from a surrogate pair is followed by a filler beat.
// A released decision passes through the bundle queue and then the result
// register. Throughput: one item per cycle while each item yields at most one
// result beat and the queue has room; the back end emits one result beat per
// cycle while the receiver takes them; an item yields up to six beats at end
// of text. The bundle queue between front and back absorbs the difference.
// Reset clears the lookahead, the queue and result_valid; the next item
// starts a new text. When the receiver stalls, the result register holds, the
// queue fills and item_ready drops.
// ----------------------------------------------------------------------------
module line_break_opportunity_stream #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  lbos_pkg::in_beat_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output lbos_pkg::out_beat_t result
);
  import lbos_pkg::*;

  logic    push;
  bundle_t push_data;
  logic    pop;
  logic    full;
  logic    not_empty;
  logic [$bits(bundle_t)-1:0] head_bits;
  bundle_t head;

  assign head = bundle_t'(head_bits);

  lbos_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .queue_full (full),
    .push       (push),
    .push_data  (push_data)
  );

  lbos_queue #(
    .WIDTH ($bits(bundle_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head_bits)
  );

  lbos_back u_back (
    .clk             (clk),
    .rst             (rst),
    .queue_not_empty (not_empty),
    .head            (head),
    .pop             (pop),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .result          (result)
  );

endmodule

FILE: tb/line_break_opportunity_stream_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_break_opportunity_stream_tb
// Drives short texts of break classes through the line break stream and
// checks every result beat against a cycle-free model of the class remapping
// and pair rules. The sender works in bursts and the receiver stalls on its
// own pattern, including one long hold-off that backs the block up.
// ----------------------------------------------------------------------------
module line_break_opportunity_stream_tb;
  import lbos_pkg::*;

  localparam int HoldStart = 300;
  localparam int HoldLen   = 150;

  class break_scoreboard;
    out_beat_t   want_q[$];
    int unsigned errors;
    int unsigned items_noted;
    int unsigned texts_done;
    int unsigned beats_checked;
    int unsigned fillers_checked;

    // Model state for the text in progress.
    cls_t        last_cls;
    logic        last_apo;
    cls_t        held_cls[2];
    logic        held_pair[2];
    int unsigned seen;

    function new();
      errors = 0;
      items_noted = 0;
      texts_done = 0;
      beats_checked = 0;
      fillers_checked = 0;
      clear_text();
    endfunction

    function void clear_text();
      last_cls = CLS_AL;
      last_apo = 1'b0;
      held_cls[0] = '0;
      held_cls[1] = '0;
      held_pair[0] = 1'b0;
      held_pair[1] = 1'b0;
      seen = 0;
    endfunction

    function cls_t map_class(cls_t raw, cls_t prev);
      if (raw > CLS_SA || raw inside {CLS_XX, CLS_SG, CLS_CB, CLS_AI}) return CLS_AL;
      if (raw == CLS_CM) return (prev == CLS_SP) ? CLS_AL : prev;
      if (raw == CLS_SA) return CLS_ID;
      if (raw == CLS_SP && prev inside {CLS_OP, CLS_B2}) return prev;
      return raw;
    endfunction

    function dec_t rule_for_pair(cls_t c, cls_t nx);
      if (c == CLS_BK) return DEC_MANDATORY;
      if (nx inside {CLS_BK, CLS_SP, CLS_ZW}) return DEC_NO_BREAK;
      if (c == CLS_ZW) return DEC_OPTIONAL;
      if (nx inside {CLS_CL, CLS_EX, CLS_IS, CLS_SY}) return DEC_NO_BREAK;
      if (c inside {CLS_OP, CLS_B2}) return DEC_NO_BREAK;
      if (c == CLS_SP) return DEC_OPTIONAL;
      if (c == CLS_GL || nx == CLS_GL) return DEC_NO_BREAK;
      if (c == CLS_QU || nx == CLS_QU) return DEC_NO_BREAK;
      if (nx inside {CLS_BA, CLS_HY, CLS_NS} || c == CLS_BB) return DEC_NO_BREAK;
      if (c == CLS_HY || nx == CLS_BB) return DEC_OPTIONAL;
      if (nx == CLS_IN && c inside {CLS_AL, CLS_ID, CLS_IN, CLS_NU}) return DEC_NO_BREAK;
      if ((c == CLS_ID && nx == CLS_PO) || (c == CLS_AL && nx == CLS_NU) ||
          (c == CLS_NU && nx == CLS_AL)) return DEC_NO_BREAK;
      if (nx == CLS_NU && c inside {CLS_HY, CLS_IS, CLS_NU, CLS_PR, CLS_SY})
        return DEC_NO_BREAK;
      if (c == CLS_PR && nx inside {CLS_AL, CLS_HY, CLS_ID, CLS_OP}) return DEC_NO_BREAK;
      if (nx == CLS_PO && c inside {CLS_CL, CLS_NU}) return DEC_NO_BREAK;
      if (c == CLS_AL && nx == CLS_AL) return DEC_NO_BREAK;
      return DEC_OPTIONAL;
    endfunction

    function dec_t position_decision(cls_t c, cls_t nx, bit is_first, bit is_final);
      dec_t d;
      if (is_first) d = (c == CLS_BK) ? DEC_MANDATORY : DEC_NO_BREAK;
      else d = rule_for_pair(c, nx);
      if (d == DEC_NO_BREAK && c == CLS_AL) d = DEC_NO_BREAK_WORD;
      if (is_final && d == DEC_NO_BREAK && c inside {CLS_SP, CLS_ZW}) d = DEC_OPTIONAL;
      return d;
    endfunction

    // One decision beat, then a filler beat when the position was a pair.
    function void push_position(dec_t d, logic pair, logic ends_text);
      out_beat_t b;
      b.decision = d;
      b.is_last = ends_text && !pair;
      want_q.push_back(b);
      if (pair) begin
        b.decision = DEC_FILLER;
        b.is_last = ends_text;
        want_q.push_back(b);
      end
    endfunction

    function void note_item(in_beat_t it);
      cls_t        cur;
      int unsigned s;
      cls_t        line_cls[3];
      logic        line_pair[3];
      int          cnt;
      cls_t        nx;
      s = seen;
      cur = map_class(it.raw_class, last_cls);
      items_noted++;
      // a'a: the apostrophe between two letters becomes a letter itself.
      if (it.raw_class == CLS_AL && s >= 2 && held_cls[0] == CLS_AL && last_apo)
        held_cls[1] = CLS_AL;
      if (!it.end_of_text) begin
        if (s >= 2)
          push_position(position_decision(held_cls[0], held_cls[1], s == 2, 1'b0),
                        held_pair[0], 1'b0);
        held_cls[0] = held_cls[1];
        held_pair[0] = held_pair[1];
        held_cls[1] = cur;
        held_pair[1] = it.is_pair;
        last_cls = cur;
        last_apo = it.is_apostrophe;
        if (seen < 3) seen++;
      end else begin
        cnt = 0;
        if (s >= 2) begin
          line_cls[cnt] = held_cls[0];
          line_pair[cnt] = held_pair[0];
          cnt++;
        end
        if (s >= 1) begin
          line_cls[cnt] = held_cls[1];
          line_pair[cnt] = held_pair[1];
          cnt++;
        end
        line_cls[cnt] = cur;
        line_pair[cnt] = it.is_pair;
        cnt++;
        for (int k = 0; k < cnt; k++) begin
          nx = (k + 1 < cnt) ? line_cls[k+1] : CLS_BK;
          push_position(position_decision(line_cls[k], nx, k == 0 && s <= 2, k + 1 == cnt),
                        line_pair[k], k + 1 == cnt);
        end
        texts_done++;
        clear_text();
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_beat(out_beat_t got);
      out_beat_t want;
      if (want_q.size() == 0) begin
        report($sformatf("result beat %0d with nothing pending (decision %0d last %0b)",
                         beats_checked, got.decision, got.is_last));
      end else begin
        want = want_q.pop_front();
        if (got.decision !== want.decision)
          report($sformatf("beat %0d decision %0d, model says %0d",
                           beats_checked, got.decision, want.decision));
        if (got.is_last !== want.is_last)
          report($sformatf("beat %0d is_last %0b, model says %0b",
                           beats_checked, got.is_last, want.is_last));
        if (want.decision == DEC_FILLER) fillers_checked++;
      end
      beats_checked++;
    endtask

    function int pending();
      return want_q.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_ready;
  in_beat_t  item = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_beat_t result;

  break_scoreboard sb;
  in_beat_t        stim_q[$];
  bit              hold_on = 1'b0;

  always #5 clk = ~clk;

  line_break_opportunity_stream DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // Outputs settle after the rising edge, so the handshake is sampled on the
  // falling edge ahead of the edge that accepts the beat.
  always @(negedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_beat(result);
  end

  function void add_beat(cls_t raw, logic apo, logic pair, logic eot);
    in_beat_t b;
    b.raw_class = raw;
    b.is_apostrophe = apo;
    b.is_pair = pair;
    b.end_of_text = eot;
    stim_q.push_back(b);
  endfunction

  function cls_t pick_class();
    int r;
    cls_t hot[12];
    hot = '{CLS_AL, CLS_SP, CLS_CM, CLS_OP, CLS_B2, CLS_BK, CLS_ZW, CLS_NU,
            CLS_ID, CLS_QU, CLS_HY, CLS_PR};
    r = $urandom_range(0, 99);
    if (r < 8) return cls_t'($urandom_range(27, 31));
    if (r < 45) return hot[$urandom_range(0, 11)];
    return cls_t'($urandom_range(0, 26));
  endfunction

  // One text of random length; mostly random classes with letter-apostrophe-
  // letter runs mixed in.
  function int add_text();
    int len;
    int r;
    int i;
    r = $urandom_range(0, 99);
    if (r < 10) len = 1;
    else if (r < 20) len = 2;
    else if (r < 30) len = 3;
    else if (r < 95) len = $urandom_range(4, 12);
    else len = $urandom_range(20, 30);
    i = 0;
    while (i < len) begin
      if (i + 3 <= len && $urandom_range(0, 9) == 0) begin
        add_beat(CLS_AL, 1'b0, $urandom_range(0, 3) == 0, 1'b0);
        add_beat(cls_t'($urandom_range(0, 31)), 1'b1, $urandom_range(0, 3) == 0, 1'b0);
        add_beat(CLS_AL, $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0,
                 i + 3 == len);
        i += 3;
      end else begin
        add_beat(pick_class(), $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0,
                 i + 1 == len);
        i++;
      end
    end
    return len;
  endfunction

  task send_all();
    int       burst_left;
    int       gap;
    in_beat_t b;
    burst_left = 0;
    while (stim_q.size() != 0) begin
      b = stim_q.pop_front();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 4) == 0 || hold_on) ? 0 : $urandom_range(1, 7);
        if (gap != 0) begin
          item_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      item_valid <= 1'b1;
      item <= b;
      do @(negedge clk); while (!item_ready);
      @(posedge clk);
      sb.note_item(b);
    end
    item_valid <= 1'b0;
  endtask

  // Receiver: random modes of random length, and one long hold-off that
  // lets the block fill up.
  initial begin : rx_pattern
    int mode;
    int span;
    int rx_cycles;
    rx_cycles = 0;
    wait (rst == 1'b0);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      repeat (span) begin
        @(posedge clk);
        rx_cycles++;
        hold_on = rx_cycles >= HoldStart && rx_cycles < HoldStart + HoldLen;
        if (hold_on) result_ready <= 1'b0;
        else begin
          case (mode)
            0: result_ready <= 1'b1;
            1: result_ready <= 1'($urandom_range(0, 1));
            2: result_ready <= ($urandom_range(0, 3) == 0);
            default: result_ready <= (rx_cycles % 4 != 3);
          endcase
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : main
    int rand_items;
    int waited;
    sb = new();

    // Lone mandatory break, lone trailing space, and a zero-width space before a break.
    add_beat(CLS_BK, 1'b0, 1'b0, 1'b1);
    add_beat(CLS_SP, 1'b0, 1'b0, 1'b1);
    add_beat(CLS_ZW, 1'b0, 1'b0, 1'b0);
    add_beat(CLS_BK, 1'b1, 1'b1, 1'b1);
    // Spaces after an opening punctuation inherit it, as does a combining mark.
    add_beat(CLS_OP, 1'b0, 1'b0, 1'b0);
    add_beat(CLS_SP, 1'b0, 1'b0, 1'b0);
    add_beat(CLS_CM, 1'b0, 1'b0, 1'b0);
    add_beat(CLS_SP, 1'b0, 1'b0, 1'b0);
    add_beat(CLS_AL, 1'b0, 1'b0, 1'b1);
    // Letter, apostrophe, letter; then a B2 run ending on a space.
    add_beat(CLS_AL, 1'b0, 1'b0, 1'b0);
    add_beat(CLS_QU, 1'b1, 1'b0, 1'b0);
    add_beat(CLS_AL, 1'b0, 1'b0, 1'b0);
    add_beat(CLS_B2, 1'b0, 1'b0, 1'b0);
    add_beat(CLS_SP, 1'b0, 1'b0, 1'b1);
    // Combining mark after a space, unknown and out-of-range classes, pairs.
    add_beat(CLS_SP, 1'b0, 1'b0, 1'b0);
    add_beat(CLS_CM, 1'b0, 1'b0, 1'b0);
    add_beat(CLS_XX, 1'b0, 1'b1, 1'b0);
    add_beat(cls_t'(31), 1'b1, 1'b1, 1'b0);
    add_beat(cls_t'(27), 1'b0, 1'b0, 1'b0);
    add_beat(CLS_SA, 1'b0, 1'b1, 1'b1);
    // Three pairs flushed at once: the most beats one item can cause.
    add_beat(CLS_AI, 1'b0, 1'b1, 1'b0);
    add_beat(CLS_CB, 1'b0, 1'b1, 1'b0);
    add_beat(CLS_SG, 1'b0, 1'b1, 1'b1);

    rand_items = 0;
    while (rand_items < 310) rand_items += add_text();

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    send_all();

    waited = 0;
    while (sb.pending() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending() != 0)
      sb.report($sformatf("%0d result beats never arrived", sb.pending()));
    repeat (20) @(posedge clk);

    $display("Ran %0d items in %0d texts; %0d result beats checked, %0d of them fillers.",
             sb.items_noted, sb.texts_done, sb.beats_checked, sb.fillers_checked);
    $display("Receiver held off for %0d cycles once, with bursty input throughout.",
             HoldLen);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/lbos_pkg.sv
rtl/core/lbos_front.sv
rtl/core/lbos_queue.sv
rtl/core/lbos_back.sv
rtl/core/line_break_opportunity_stream.sv
tb/line_break_opportunity_stream_tb.sv
